[design/bon_pkg.sv]
// Shared register indexes and mode encodings of the box overlap suppression block.
package bon_pkg;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 17;
  localparam logic [CfgIdxBits-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgGreedy = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgMode = 2'd2;

  localparam logic [1:0] ModeUnion = 2'd0;
  localparam logic [1:0] ModeMin = 2'd1;
  localparam logic [1:0] ModeFirst = 2'd2;

endpackage

[design/box_overlap_nms_top.sv]
// Top level of the box overlap non-maximum suppression block.
//
// Boxes enter on the s_axis channel, one per accepted request; tlast marks the
// last box of a set. After the last box the block stops accepting and runs
// pairwise checks with one pipelined overlap unit: for each box i it reads box i
// as the reference, compares it with each later box j still kept, and then
// drains the pipeline. Survivors are then sent on m_axis in order, with tlast
// on the last one; the next survivor is looked up only after the current result
// is taken. If none survive, one empty result is sent. A stall on the output
// simply holds the current result. Boxes past MAX_BOXES are dropped and flagged
// in every result of the set. Reset clears the set and loads the register
// defaults: threshold 32768, greedy mode on, union mode. The box memory has no
// reset; only stored entries are used.
module box_overlap_nms_top
  import bon_pkg::*;
#(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_edge, top_edge, right_edge, bottom_edge
  input  logic [4*COORD_BITS-1:0] s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // kept_left, kept_top, kept_right, kept_bottom
  output logic [4*COORD_BITS-1:0] m_axis_tdata,
  // box_present, capacity_overflow
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);
  localparam int unsigned IB = $clog2(MAX_BOXES);
  localparam int unsigned CB = IB + 1;
  localparam int unsigned BW = 4 * COORD_BITS;
  localparam int unsigned Lat = 3;

  typedef enum logic [2:0] {
    StLoad, StSetI, StWaitI, StCmp, StDrain, StOutRd, StOutWait, StOut
  } state_e;

  state_e            state_q;
  logic [16:0]       thr_q;
  logic              greedy_q;
  logic [1:0]        mode_q;
  logic [CB-1:0]     cnt_q, i_q, j_q, ocnt_q;
  logic [MAX_BOXES-1:0] keep_q;
  logic              ovf_q, found_q;
  logic [BW-1:0]     a_q;
  logic [IB-1:0]     pj_q [Lat+1];
  logic [Lat:0]      pv_q;
  logic [2:0]        drain_q;
  logic              we;
  logic [IB-1:0]     raddr;
  logic [BW-1:0]     rdata;
  logic              supp;
  logic [IB-1:0]     rd_j_q;

  assign s_axis_tready = (state_q == StLoad);
  assign we = s_axis_tvalid && s_axis_tready && (cnt_q < CB'(MAX_BOXES));

  // Read address: box i for the reference, then later boxes j, then output scan.
  always_comb begin
    case (state_q)
      StSetI:  raddr = i_q[IB-1:0];
      StCmp:   raddr = j_q[IB-1:0];
      default: raddr = ocnt_q[IB-1:0];
    endcase
  end

  bon_ram #(.Width(BW), .Depth(MAX_BOXES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IB-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bon_overlap #(.CoordBits(COORD_BITS)) u_ovl (
    .clk_i   (clk_i),
    .box_a_i (a_q),
    .box_b_i (rdata),
    .thr_i   (thr_q),
    .mode_i  (mode_q),
    .supp_o  (supp)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= 17'd32768;
      greedy_q <= 1'b1;
      mode_q   <= ModeUnion;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold: thr_q <= cfg_data_i;
        CfgGreedy:    greedy_q <= cfg_data_i[0];
        CfgMode:      mode_q <= cfg_data_i[1:0];
        default:      ;
      endcase
    end
  end

  // Compare pipeline tracking: RAM read (1) + overlap unit (3).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q[0] <= (state_q == StCmp) && (j_q < cnt_q) && keep_q[j_q[IB-1:0]];
      for (int k = 1; k <= Lat; k++) pv_q[k] <= pv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pj_q[0] <= j_q[IB-1:0];
    for (int k = 1; k <= Lat; k++) pj_q[k] <= pj_q[k-1];
  end

  // Sequencer: load, pairwise suppression, output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StLoad;
      cnt_q         <= '0;
      i_q           <= '0;
      j_q           <= '0;
      ocnt_q        <= '0;
      keep_q        <= '1;
      ovf_q         <= 1'b0;
      found_q       <= 1'b0;
      drain_q       <= '0;
      rd_j_q        <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
      m_axis_tuser  <= '0;
    end else begin
      if (pv_q[Lat] && supp) keep_q[pj_q[Lat]] <= 1'b0;
      unique case (state_q)
        StLoad: begin
          if (s_axis_tvalid) begin
            if (we) cnt_q <= cnt_q + 1'b1;
            else ovf_q <= 1'b1;
            if (s_axis_tlast) begin
              i_q     <= '0;
              state_q <= StSetI;
            end
          end
        end
        StSetI: begin
          if (i_q >= cnt_q) begin
            ocnt_q  <= '0;
            found_q <= 1'b0;
            state_q <= StOutRd;
          end else if (greedy_q && !keep_q[i_q[IB-1:0]]) begin
            i_q <= i_q + 1'b1;
          end else begin
            state_q <= StWaitI;
          end
        end
        StWaitI: begin
          j_q     <= i_q + 1'b1;
          state_q <= StCmp;
        end
        StCmp: begin
          if (j_q >= cnt_q) begin
            drain_q <= 3'(Lat + 1);
            state_q <= StDrain;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        StDrain: begin
          if (drain_q == '0) begin
            i_q     <= i_q + 1'b1;
            state_q <= StSetI;
          end else begin
            drain_q <= drain_q - 1'b1;
          end
        end
        StOutRd: begin
          // Find next survivor; ocnt_q reads it from RAM.
          if (ocnt_q >= cnt_q) begin
            if (!found_q) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tlast  <= 1'b1;
              m_axis_tuser  <= {ovf_q, 1'b0};
              state_q       <= StOut;
            end else begin
              state_q <= StLoad;
            end
          end else if (keep_q[ocnt_q[IB-1:0]]) begin
            rd_j_q  <= ocnt_q[IB-1:0];
            state_q <= StOutWait;
          end else begin
            ocnt_q <= ocnt_q + 1'b1;
          end
        end
        StOutWait: begin
          // Data of rd_j_q is on rdata; look ahead for a later stored survivor.
          m_axis_tvalid <= 1'b1;
          m_axis_tuser  <= {ovf_q, 1'b1};
          m_axis_tlast  <= (((keep_q & ~({MAX_BOXES{1'b1}} << cnt_q)) >>
                             (rd_j_q + 1'b1)) == '0) ||
                           (rd_j_q == IB'(MAX_BOXES - 1)) ||
                           (CB'(rd_j_q) + 1'b1 >= cnt_q);
          found_q       <= 1'b1;
          state_q       <= StOut;
        end
        StOut: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              cnt_q   <= '0;
              keep_q  <= '1;
              ovf_q   <= 1'b0;
              state_q <= StLoad;
            end else begin
              ocnt_q  <= CB'(rd_j_q) + 1'b1;
              state_q <= StOutRd;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Reference box capture and output payload.
  always_ff @(posedge clk_i) begin
    if (state_q == StWaitI) a_q <= rdata;
    if (state_q == StOutWait) m_axis_tdata <= rdata;
    else if (state_q == StOutRd && ocnt_q >= cnt_q && !found_q) m_axis_tdata <= '0;
  end
endmodule

[design/bon_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bon_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/bon_overlap.sv]
// Shared pairwise overlap unit: registered intersection, areas, then products and compare.
module bon_overlap
  import bon_pkg::*;
#(
  parameter int unsigned CoordBits = 16
) (
  input  logic                   clk_i,
  input  logic [4*CoordBits-1:0] box_a_i,
  input  logic [4*CoordBits-1:0] box_b_i,
  input  logic [16:0]            thr_i,
  input  logic [1:0]             mode_i,
  output logic                   supp_o
);
  localparam int unsigned DB = CoordBits + 1;
  localparam int unsigned AB = 2 * DB;
  localparam int unsigned NB = AB + 1;
  localparam int unsigned PB = NB + 17;

  logic signed [CoordBits-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic signed [CoordBits-1:0] ix0, iy0, ix1, iy1;
  logic [DB-1:0] aw_q, ah_q, bw_q, bh_q, iw_q, ih_q;
  logic          ok_q, iok_q;
  logic [AB-1:0] sa_q, sb_q, in_q;
  logic          ok2_q;
  logic [NB-1:0] den;
  logic [PB-1:0] lhs_q, rhs_q;
  logic          ok3_q;

  assign {ay1, ax1, ay0, ax0} = box_a_i;
  assign {by1, bx1, by0, bx0} = box_b_i;
  assign ix0 = (ax0 > bx0) ? ax0 : bx0;
  assign iy0 = (ay0 > by0) ? ay0 : by0;
  assign ix1 = (ax1 < bx1) ? ax1 : bx1;
  assign iy1 = (ay1 < by1) ? ay1 : by1;

  // Stage 1: side lengths and validity.
  always_ff @(posedge clk_i) begin
    ok_q  <= (ax1 >= ax0) && (ay1 >= ay0) && (bx1 >= bx0) && (by1 >= by0);
    iok_q <= (ix0 <= ix1) && (iy0 <= iy1);
    aw_q  <= DB'($signed({ax1[CoordBits-1], ax1}) - $signed({ax0[CoordBits-1], ax0}) + 1);
    ah_q  <= DB'($signed({ay1[CoordBits-1], ay1}) - $signed({ay0[CoordBits-1], ay0}) + 1);
    bw_q  <= DB'($signed({bx1[CoordBits-1], bx1}) - $signed({bx0[CoordBits-1], bx0}) + 1);
    bh_q  <= DB'($signed({by1[CoordBits-1], by1}) - $signed({by0[CoordBits-1], by0}) + 1);
    iw_q  <= DB'($signed({ix1[CoordBits-1], ix1}) - $signed({ix0[CoordBits-1], ix0}) + 1);
    ih_q  <= DB'($signed({iy1[CoordBits-1], iy1}) - $signed({iy0[CoordBits-1], iy0}) + 1);
  end

  // Stage 2: areas.
  always_ff @(posedge clk_i) begin
    ok2_q <= ok_q;
    sa_q  <= aw_q * ah_q;
    sb_q  <= bw_q * bh_q;
    in_q  <= iok_q ? AB'(iw_q * ih_q) : '0;
  end

  // Denominator selection.
  always_comb begin
    case (mode_i)
      ModeMin:   den = NB'((sa_q < sb_q) ? sa_q : sb_q);
      ModeFirst: den = NB'(sa_q);
      default:   den = NB'(sa_q) + NB'(sb_q) - NB'(in_q);
    endcase
  end

  // Stage 3: cross products; a zero denominator clears the valid flag, so no suppression.
  always_ff @(posedge clk_i) begin
    ok3_q <= ok2_q && (den != '0);
    lhs_q <= PB'({in_q, 16'd0});
    rhs_q <= PB'(den) * PB'(thr_i);
  end

  assign supp_o = ok3_q && (lhs_q > rhs_q);
endmodule
